[rtl/frame_difference_event_generator_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef FRAME_DIFFERENCE_EVENT_GENERATOR_CORE_DEFINES_SVH
`define FRAME_DIFFERENCE_EVENT_GENERATOR_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FDEG_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property that must hold in the cycle after a trigger, outside reset.
`define FDEG_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

[rtl/fdeg_pkg.sv]
package fdeg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DIM_BITS    = COORD_BITS + 1;
    localparam int ADDR_BITS   = 21;
    localparam int MAX_PIXELS  = 1 << ADDR_BITS;
    localparam int LUMA_BITS   = 18;
    localparam int STRIDE_BITS = 7;
    localparam int CNT_BITS    = 22;
    localparam int TIME_BITS   = 64;
    localparam int COLOR_BITS  = 8;
    localparam int PROD_BITS   = COORD_BITS + DIM_BITS;
    localparam int STEP_BITS   = $clog2(COORD_BITS);

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = CNT_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_STRIDE    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANGE_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_EVENTS       = 3'd4;

    localparam logic [DIM_BITS-1:0]    FRAME_WIDTH_RESET  = DIM_BITS'(1920);
    localparam logic [DIM_BITS-1:0]    FRAME_HEIGHT_RESET = DIM_BITS'(1080);
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET       = STRIDE_BITS'(1);
    localparam logic [LUMA_BITS-1:0]   THRESHOLD_RESET    = LUMA_BITS'(15360);
    localparam logic [CNT_BITS-1:0]    MAX_EVENTS_RESET   = CNT_BITS'(65536);

    // Q10 luminance weights (0.299, 0.587, 0.114 times 1024)
    localparam int unsigned W_RED   = 306;
    localparam int unsigned W_GREEN = 601;
    localparam int unsigned W_BLUE  = 117;

    typedef logic [LUMA_BITS-1:0] luma_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  cmp_en;
        logic                  clr_before;
        logic                  clr_after;
    } pix_ctl_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] top;
        top = DIM_BITS'(1) << COORD_BITS;
        if (v == '0)
            return DIM_BITS'(1);
        return (v > top) ? top : v;
    endfunction

    function automatic luma_t luma_of(input logic [COLOR_BITS-1:0] r,
                                      input logic [COLOR_BITS-1:0] g,
                                      input logic [COLOR_BITS-1:0] b);
        return LUMA_BITS'(W_RED * r + W_GREEN * g + W_BLUE * b);
    endfunction

endpackage

[rtl/fdeg_raster.sv]
module fdeg_raster import fdeg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   sof,
    input  logic [TIME_BITS-1:0]   frame_time,
    input  logic [DIM_BITS-1:0]    frame_width,
    input  logic [DIM_BITS-1:0]    frame_height,
    input  logic [STRIDE_BITS-1:0] sample_stride,
    input  logic                   stride_load,
    output pix_ctl_t               ctl,
    output logic [TIME_BITS-1:0]   item_time,
    output logic                   busy
);

    logic [COORD_BITS-1:0]  col_reg, row_reg;
    logic [STRIDE_BITS-1:0] cph_reg, rph_reg;
    logic                   pend_reg;
    logic [TIME_BITS-1:0]   time_reg;
    logic                   busy_reg;
    logic [STEP_BITS-1:0]   step_reg;

    logic [DIM_BITS-1:0]    w, h;
    logic [STRIDE_BITS-1:0] s;
    logic [COORD_BITS-1:0]  col_base, row_base, col0, row0;
    logic                   col_fold, row_fold, end_col, end_frame;
    logic [STRIDE_BITS-1:0] cph0, rph0, cph_inc, rph_inc;

    // one restoring-remainder step: shift in a bit, subtract the divisor if it fits
    function automatic logic [STRIDE_BITS-1:0] mod_step(input logic [STRIDE_BITS-1:0] r,
                                                        input logic b,
                                                        input logic [STRIDE_BITS-1:0] d);
        logic [STRIDE_BITS:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
            t = t - {1'b0, d};
        return t[STRIDE_BITS-1:0];
    endfunction

    always_comb
    begin
        w        = clamp_dim(frame_width);
        h        = clamp_dim(frame_height);
        s        = (sample_stride == '0) ? STRIDE_BITS'(1) : sample_stride;
        col_base = sof ? '0 : col_reg;
        row_base = sof ? '0 : row_reg;
        col_fold = ({1'b0, col_base} >= w);
        row_fold = ({1'b0, row_base} >= h);
        col0     = col_fold ? '0 : col_base;
        row0     = row_fold ? '0 : row_base;
        cph0     = (sof || col_fold) ? '0 : cph_reg;
        rph0     = (sof || row_fold) ? '0 : rph_reg;
        end_col  = ({1'b0, col0} + DIM_BITS'(1)) >= w;
        end_frame = end_col && (({1'b0, row0} + DIM_BITS'(1)) >= h);
        cph_inc  = (cph0 + STRIDE_BITS'(1) == s) ? '0 : cph0 + STRIDE_BITS'(1);
        rph_inc  = (rph0 + STRIDE_BITS'(1) == s) ? '0 : rph0 + STRIDE_BITS'(1);
    end

    assign ctl.col        = col0;
    assign ctl.row        = row0;
    assign ctl.cmp_en     = !pend_reg && (cph0 == '0) && (rph0 == '0);
    assign ctl.clr_before = sof;
    assign ctl.clr_after  = end_frame;
    assign item_time      = sof ? frame_time : time_reg;
    assign busy           = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= 1'b1;
            time_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= end_col ? '0 : col0 + COORD_BITS'(1);
            if (end_col)
                row_reg <= end_frame ? '0 : row0 + COORD_BITS'(1);
            else
                row_reg <= row0;
            if (end_frame)
                pend_reg <= 1'b0;
            if (sof)
                time_reg <= frame_time;
        end
    end

    // Stride phases; a stride write recomputes them bit-serially from the position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cph_reg  <= '0;
            rph_reg  <= '0;
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (stride_load)
        begin
            cph_reg  <= '0;
            rph_reg  <= '0;
            busy_reg <= 1'b1;
            step_reg <= STEP_BITS'(COORD_BITS - 1);
        end
        else if (busy_reg)
        begin
            cph_reg <= mod_step(cph_reg, col_reg[step_reg], s);
            rph_reg <= mod_step(rph_reg, row_reg[step_reg], s);
            if (step_reg == '0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - STEP_BITS'(1);
        end
        else if (accept)
        begin
            cph_reg <= end_col ? '0 : cph_inc;
            if (end_col)
                rph_reg <= end_frame ? '0 : rph_inc;
            else
                rph_reg <= rph0;
        end
    end

endmodule

[rtl/fdeg_store.sv]
module fdeg_store import fdeg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  rd_en,
    input  addr_t rd_addr,
    input  logic  wr_en,
    input  addr_t wr_addr,
    input  luma_t wr_data,
    output luma_t rd_data
);

    luma_t mem [0:MAX_PIXELS-1];
    luma_t mem_q_reg;
    luma_t fwd_data_reg;
    logic  fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // bypass a write landing on the address being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (rd_en)
            fwd_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

[rtl/fdeg_event.sv]
module fdeg_event import fdeg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  logic                 leave,
    input  pix_ctl_t             ctl,
    input  luma_t                luma,
    input  luma_t                prev,
    input  logic [LUMA_BITS-1:0] threshold,
    input  logic [CNT_BITS-1:0]  max_events,
    output logic                 fire,
    output logic                 polarity
);

    logic [CNT_BITS-1:0] cnt_reg, cnt_eff, cnt_next;
    luma_t               diff;
    logic                rise;

    always_comb
    begin
        rise     = luma > prev;
        diff     = rise ? luma - prev : prev - luma;
        cnt_eff  = ctl.clr_before ? '0 : cnt_reg;
        fire     = valid && ctl.cmp_en && (diff > threshold) && (cnt_eff < max_events);
        cnt_next = ctl.clr_after ? '0 : cnt_eff + CNT_BITS'(fire);
    end

    assign polarity = rise;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (leave)
            cnt_reg <= cnt_next;
    end

endmodule

[rtl/frame_difference_event_generator_core.sv]
// An event passes the stage 1, stage 2 and output registers before it shows on the output.
// Throughput: one pixel per cycle while input is not stalled; the output register frees the input side.
// A write to sample_stride stalls input while the stride phases are
// recomputed one coordinate bit per cycle.
// Reset (rst_n, asynchronous): position, counters and valids clear, configuration registers take
// their reset values; the luma store keeps its contents and the first full frame only fills it.
module frame_difference_event_generator_core import fdeg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [COLOR_BITS-1:0]     blue,
    input  logic [COLOR_BITS-1:0]     green,
    input  logic [COLOR_BITS-1:0]     red,
    input  logic                      start_of_frame,
    input  logic [TIME_BITS-1:0]      frame_time,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COORD_BITS-1:0]     event_x,
    output logic [COORD_BITS-1:0]     event_y,
    output logic                      polarity,
    output logic [TIME_BITS-1:0]      event_time,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers
    logic [DIM_BITS-1:0]    frame_width_reg, frame_height_reg;
    logic [STRIDE_BITS-1:0] sample_stride_reg;
    logic [LUMA_BITS-1:0]   change_threshold_reg;
    logic [CNT_BITS-1:0]    max_events_reg;
    logic                   cfg_write, stride_load;

    // Handshake and pipeline control
    logic accept, busy, fire2, pol2;
    logic out_free, s2_go, en2, en1, leave2, rd_en;

    // Stage 1: registered pixel with its raster position
    logic                  v1_reg;
    pix_ctl_t              ctl1_reg;
    logic [COLOR_BITS-1:0] blue1_reg, green1_reg, red1_reg;
    logic [TIME_BITS-1:0]  time1_reg;
    luma_t                 luma1;
    addr_t                 addr1;
    logic [PROD_BITS-1:0]  addr_full;

    // Stage 2: store read data returns, compare and write back
    logic                  v2_reg;
    pix_ctl_t              ctl2_reg;
    luma_t                 luma2_reg, prev2;
    addr_t                 addr2_reg;
    logic [TIME_BITS-1:0]  time2_reg;

    // Raster tracker output for the pixel on the input ports
    pix_ctl_t              ctl0;
    logic [TIME_BITS-1:0]  time0;

    // Output register
    logic                  out_v_reg, pol_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [TIME_BITS-1:0]  etime_reg;

    // ------------------------------------------------------------------
    // Configuration port: always ready, unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign stride_load = cfg_write && (cfg_index == REG_SAMPLE_STRIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= FRAME_WIDTH_RESET;
            frame_height_reg     <= FRAME_HEIGHT_RESET;
            sample_stride_reg    <= STRIDE_RESET;
            change_threshold_reg <= THRESHOLD_RESET;
            max_events_reg       <= MAX_EVENTS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:      frame_width_reg      <= cfg_data[DIM_BITS-1:0];
                REG_FRAME_HEIGHT:     frame_height_reg     <= cfg_data[DIM_BITS-1:0];
                REG_SAMPLE_STRIDE:    sample_stride_reg    <= cfg_data[STRIDE_BITS-1:0];
                REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data[LUMA_BITS-1:0];
                REG_MAX_EVENTS:       max_events_reg       <= cfg_data[CNT_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Stage 2 holds only when it has an event and the output
    // register is full and stalled; everything upstream then holds too.
    // A pixel that makes no event passes stage 2 regardless of the output.
    // ------------------------------------------------------------------
    assign out_free = !out_v_reg || !out_stall;
    assign s2_go    = !fire2 || out_free;
    assign en2      = !v2_reg || s2_go;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1 || busy;
    assign accept   = in_valid && !in_stall;
    assign leave2   = v2_reg && s2_go;
    assign rd_en    = en2 && v1_reg;

    // ------------------------------------------------------------------
    // Raster position, stride grid, reference-frame flag, time latch
    // ------------------------------------------------------------------
    fdeg_raster u_raster (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .sof           (start_of_frame),
        .frame_time    (frame_time),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .sample_stride (sample_stride_reg),
        .stride_load   (stride_load),
        .ctl           (ctl0),
        .item_time     (time0),
        .busy          (busy)
    );

    // ------------------------------------------------------------------
    // Stage 1: hold the accepted pixel, form luma and the store address.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl1_reg   <= ctl0;
            blue1_reg  <= blue;
            green1_reg <= green;
            red1_reg   <= red;
            time1_reg  <= time0;
        end
    end

    // Raster address row*width + column, wrapped to the store size
    always_comb
    begin
        luma1     = luma_of(red1_reg, green1_reg, blue1_reg);
        addr_full = PROD_BITS'(ctl1_reg.row) * PROD_BITS'(clamp_dim(frame_width_reg))
                  + PROD_BITS'(ctl1_reg.col);
        addr1     = ADDR_BITS'(addr_full);
    end

    // ------------------------------------------------------------------
    // Luma store: read for stage 1's pixel as it advances, write stage 2's
    // pixel as it leaves. Same-address overlap is bypassed inside the store.
    // ------------------------------------------------------------------
    fdeg_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (addr1),
        .wr_en   (leave2),
        .wr_addr (addr2_reg),
        .wr_data (luma2_reg),
        .rd_data (prev2)
    );

    // ------------------------------------------------------------------
    // Stage 2
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ctl2_reg  <= ctl1_reg;
            luma2_reg <= luma1;
            addr2_reg <= addr1;
            time2_reg <= time1_reg;
        end
    end

    // Threshold test and per-frame event cap
    fdeg_event u_event (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (v2_reg),
        .leave      (leave2),
        .ctl        (ctl2_reg),
        .luma       (luma2_reg),
        .prev       (prev2),
        .threshold  (change_threshold_reg),
        .max_events (max_events_reg),
        .fire       (fire2),
        .polarity   (pol2)
    );

    // ------------------------------------------------------------------
    // Output register: load an event when the slot is free, hold it while stalled.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_free)
            out_v_reg <= fire2;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && fire2)
        begin
            x_reg     <= ctl2_reg.col;
            y_reg     <= ctl2_reg.row;
            pol_reg   <= pol2;
            etime_reg <= time2_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign event_x    = x_reg;
    assign event_y    = y_reg;
    assign polarity   = pol_reg;
    assign event_time = etime_reg;

endmodule

[rtl/fdeg_checker.sv]
`include "frame_difference_event_generator_core_defines.svh"

module fdeg_checker import fdeg_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [COORD_BITS-1:0]     event_x,
    input logic [COORD_BITS-1:0]     event_y,
    input logic                      polarity,
    input logic [TIME_BITS-1:0]      event_time,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFG_INDEX_BITS-1:0] cfg_index
);

    // hold a stalled event
    `FDEG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "event dropped while stalled")

    `FDEG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(event_x) && $stable(event_y) && $stable(polarity) && $stable(event_time), "event changed while stalled")

    // config is never back-pressured
    `FDEG_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")

    // a stride write must pause input while the phases are rebuilt
    `FDEG_ASSERT_NEXT(a_stride_pause, cfg_valid && cfg_ready && cfg_index == REG_SAMPLE_STRIDE, in_stall, "input not held after stride write")

endmodule

bind frame_difference_event_generator_core fdeg_checker u_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import fdeg_pkg::*;

    // Run length and pacing
    localparam int unsigned CYCLE_LIMIT   = 700_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 760;
    localparam int unsigned FILL_PIXELS   = 256;
    localparam int unsigned FULL_SCALE    = 1 << COORD_BITS;
    localparam int unsigned LUMA_TOP      = 261120;
    localparam int unsigned CAP_MAX       = (1 << CNT_BITS) - 1;
    localparam int unsigned DIM_MAX       = (1 << DIM_BITS) - 1;
    localparam int unsigned STRIDE_MAX    = (1 << STRIDE_BITS) - 1;
    localparam int unsigned THRESH_MAX    = (1 << LUMA_BITS) - 1;

    // Byte lanes of a packed {red, green, blue} pixel
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam logic [23:0] BLACK = 24'h000000;
    localparam logic [23:0] WHITE = 24'hFFFFFF;

    localparam logic [4:0] ALL_REGS = 5'b11111;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  pol;
        logic [TIME_BITS-1:0]  stamp;
    } dvs_event_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                      in_valid;
    logic                      in_stall;
    logic [COLOR_BITS-1:0]     blue;
    logic [COLOR_BITS-1:0]     green;
    logic [COLOR_BITS-1:0]     red;
    logic                      start_of_frame;
    logic [TIME_BITS-1:0]      frame_time;

    logic                      out_valid;
    logic                      out_stall;
    logic [COORD_BITS-1:0]     event_x;
    logic [COORD_BITS-1:0]     event_y;
    logic                      polarity;
    logic [TIME_BITS-1:0]      event_time;

    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    frame_difference_event_generator_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .start_of_frame (start_of_frame),
        .frame_time     (frame_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_x        (event_x),
        .event_y        (event_y),
        .polarity       (polarity),
        .event_time     (event_time),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the block: registers, raster position, luma store
    logic [DIM_BITS-1:0]    reg_width      = FRAME_WIDTH_RESET;
    logic [DIM_BITS-1:0]    reg_height     = FRAME_HEIGHT_RESET;
    logic [STRIDE_BITS-1:0] reg_stride     = STRIDE_RESET;
    luma_t                  reg_threshold  = THRESHOLD_RESET;
    logic [CNT_BITS-1:0]    reg_max_events = MAX_EVENTS_RESET;

    bit                     ref_pending  = 1'b1;
    int unsigned            cur_col      = 0;
    int unsigned            cur_row      = 0;
    int unsigned            frame_events = 0;
    logic [TIME_BITS-1:0]   cur_time     = '0;

    luma_t                  luma_mem [addr_t];
    // Last color written per address, so new pixels can be placed near the old luma
    logic [23:0]            last_rgb [addr_t];

    dvs_event_t             expected_events [$];

    int unsigned            mismatch_count = 0;
    int unsigned            cycle_count    = 0;
    int unsigned            hold_request   = 0;
    bit                     send_idle      = 1'b1;
    bit                     recv_idle      = 1'b1;

    // Clamp a geometry register the way the datapath does: 0 acts as 1, top at 2^COORD_BITS
    function automatic int unsigned eff_dim(input logic [DIM_BITS-1:0] v);
        if (v == '0)
            return 1;
        return (v > FULL_SCALE) ? FULL_SCALE : int'(v);
    endfunction

    // Store address the next pixel lands on, with or without a start of frame
    function automatic addr_t peek_addr(input bit sof);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        w = eff_dim(reg_width);
        h = eff_dim(reg_height);
        c = sof ? 0 : cur_col;
        r = sof ? 0 : cur_row;
        if (c >= w)
            c = 0;
        if (r >= h)
            r = 0;
        return addr_t'(r * w + c);
    endfunction

    // Move one color lane by d, reflecting when it would leave 0..255
    function automatic logic [23:0] nudge(input logic [23:0] base, input int ch, input int d);
        logic [23:0] px;
        int          v;
        px = base;
        v  = base[ch*8 +: 8];
        v  = (v + d >= 0 && v + d <= 255) ? v + d : v - d;
        px[ch*8 +: 8] = 8'(v);
        return px;
    endfunction

    // Mostly repeat or slightly move the stored color; sometimes jump anywhere
    function automatic logic [23:0] pick_pixel(input addr_t a);
        logic [23:0] base;
        int          d;
        base = last_rgb.exists(a) ? last_rgb[a] : 24'($urandom);
        d    = $urandom_range(1, 8);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return base;
            4, 5, 6:    return nudge(base, $urandom_range(CH_BLUE, CH_RED),
                                     $urandom_range(0, 1) ? d : -d);
            7:          return $urandom_range(0, 1) ? WHITE : BLACK;
            default:    return 24'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // Advance the shadow raster by one accepted pixel and queue the event it causes
    task automatic predict_pixel(input logic [23:0] rgb, input bit sof,
                                 input logic [TIME_BITS-1:0] ftime);
        int unsigned w;
        int unsigned h;
        int unsigned pitch;
        int unsigned luma;
        int unsigned prev;
        int unsigned diff;
        addr_t       a;
        dvs_event_t  ev;
        w     = eff_dim(reg_width);
        h     = eff_dim(reg_height);
        pitch = (reg_stride == '0) ? 1 : int'(reg_stride);
        if (sof)
        begin
            cur_col      = 0;
            cur_row      = 0;
            frame_events = 0;
            cur_time     = ftime;
        end
        // fold back a position left over from a larger geometry
        if (cur_col >= w)
            cur_col = 0;
        if (cur_row >= h)
            cur_row = 0;
        a    = peek_addr(1'b0);
        luma = W_RED * rgb[23:16] + W_GREEN * rgb[15:8] + W_BLUE * rgb[7:0];
        prev = luma_mem.exists(a) ? int'(luma_mem[a]) : 0;
        if (!ref_pending && cur_col % pitch == 0 && cur_row % pitch == 0)
        begin
            diff = (luma > prev) ? luma - prev : prev - luma;
            if (diff > reg_threshold && frame_events < reg_max_events)
            begin
                frame_events++;
                ev.x     = COORD_BITS'(cur_col);
                ev.y     = COORD_BITS'(cur_row);
                ev.pol   = (luma > prev);
                ev.stamp = cur_time;
                expected_events.insert(expected_events.size(), ev);
            end
        end
        luma_mem[a] = luma_t'(luma);
        last_rgb[a] = rgb;
        // step the raster; the last pixel of a frame wraps and closes the frame
        if (cur_col + 1 >= w)
        begin
            cur_col = 0;
            if (cur_row + 1 >= h)
            begin
                cur_row      = 0;
                frame_events = 0;
                ref_pending  = 1'b0;
            end
            else
                cur_row++;
        end
        else
            cur_col++;
    endtask

    // Offer one pixel, after a random gap if send_idle is set; hold it until the block takes it
    task automatic send_pixel(input logic [23:0] rgb, input bit sof,
                              input logic [TIME_BITS-1:0] ftime);
        int gap;
        gap = send_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        red            <= rgb[23:16];
        green          <= rgb[15:8];
        blue           <= rgb[7:0];
        start_of_frame <= sof;
        frame_time     <= ftime;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel(rgb, sof, ftime);
    endtask

    task automatic send_random(input bit sof);
        send_pixel(pick_pixel(peek_addr(sof)), sof, rand_time());
    endtask

    // Drive one register write and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
        logic [CFG_DATA_BITS-1:0] data;
        data = CFG_DATA_BITS'(value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:      reg_width      = data[DIM_BITS-1:0];
            REG_FRAME_HEIGHT:     reg_height     = data[DIM_BITS-1:0];
            REG_SAMPLE_STRIDE:    reg_stride     = data[STRIDE_BITS-1:0];
            REG_CHANGE_THRESHOLD: reg_threshold  = data[LUMA_BITS-1:0];
            REG_MAX_EVENTS:       reg_max_events = data[CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Wait until every queued event has come out, then let the pipeline empty
    task automatic wait_idle();
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Quiesce the block, then write the registers selected by mask
    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned s,
                             input int unsigned t, input int unsigned m,
                             input logic [4:0] mask);
        in_valid <= 1'b0;
        wait_idle();
        if (mask[REG_FRAME_WIDTH])
            write_reg(REG_FRAME_WIDTH, w);
        if (mask[REG_FRAME_HEIGHT])
            write_reg(REG_FRAME_HEIGHT, h);
        if (mask[REG_SAMPLE_STRIDE])
            write_reg(REG_SAMPLE_STRIDE, s);
        if (mask[REG_CHANGE_THRESHOLD])
            write_reg(REG_CHANGE_THRESHOLD, t);
        if (mask[REG_MAX_EVENTS])
            write_reg(REG_MAX_EVENTS, m);
        cfg_valid <= 1'b0;
    endtask

    // Truncate a reference frame at reset geometry, then fill one FILL_PIXELS-wide row.
    // Later tests keep every pixel on the filled addresses.
    task automatic test_reference_fill();
        for (int i = 0; i < 10; i++)
            send_random(i == 0);
        configure(FILL_PIXELS, 1, 1, 0, CAP_MAX, ALL_REGS);
        for (int i = 0; i < FILL_PIXELS; i++)
            send_random(i == 0);
    endtask

    // Threshold edges on each color lane, extreme colors, wrap without start of frame,
    // unit frames from zero geometry, full-swing threshold, and an event cap of zero.
    task automatic test_directed();
        logic [23:0] base;
        logic [23:0] px;
        addr_t       a;
        configure(4, 3, 1, W_RED * 5, CAP_MAX, ALL_REGS);
        for (int i = 0; i < 14; i++)
        begin
            a    = peek_addr(i == 0);
            base = last_rgb[a];
            case (i)
                0, 10:   px = BLACK;
                1, 9:    px = WHITE;
                2:       px = nudge(base, CH_RED, 5);
                3:       px = nudge(base, CH_RED, 6);
                4:       px = base;
                5:       px = nudge(base, CH_GREEN, 2);
                6:       px = nudge(base, CH_GREEN, 3);
                7:       px = nudge(base, CH_BLUE, 13);
                8:       px = nudge(base, CH_BLUE, 14);
                default: px = pick_pixel(a);
            endcase
            send_pixel(px, i == 0, (i == 0) ? '1 : rand_time());
        end
        // zero width, height and stride act as one: every pixel is a frame
        configure(0, 0, 0, LUMA_TOP, 1, ALL_REGS);
        send_pixel(BLACK, 1'b1, rand_time());
        send_pixel(WHITE, 1'b0, rand_time());
        send_pixel(BLACK, 1'b0, rand_time());
        configure(0, 0, 0, 0, 1, 5'b1 << REG_CHANGE_THRESHOLD);
        send_pixel(WHITE, 1'b0, rand_time());
        send_pixel(BLACK, 1'b0, rand_time());
        send_pixel(BLACK, 1'b0, rand_time());
        configure(0, 0, 0, 0, 0, 5'b1 << REG_MAX_EVENTS);
        send_pixel(WHITE, 1'b0, rand_time());
    endtask

    // Width above the top clamps to 4096; run along the first row of the filled addresses
    task automatic test_wide_rows();
        configure(DIM_MAX, 1, 1, W_BLUE * 4, CAP_MAX, ALL_REGS);
        for (int i = 0; i < FILL_PIXELS; i++)
            send_random(i == 0);
    endtask

    // Phases of random geometry and thresholds; mostly whole frames, some truncated
    task automatic test_random_phases();
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned t;
        int unsigned m;
        int unsigned n_pix;
        int unsigned sent;
        logic [4:0]  mask;
        bit          sof;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // pick a geometry, some of them larger than the filled part of the store
            case ($urandom_range(0, 9))
                0:
                begin
                    w = $urandom_range(0, 1);
                    h = $urandom_range(0, 3);
                end
                1:
                begin
                    case ($urandom_range(0, 2))
                        0:       w = FULL_SCALE;
                        1:       w = FULL_SCALE + 1;
                        default: w = DIM_MAX;
                    endcase
                    h = $urandom_range(0, 1);
                end
                2:
                begin
                    w = $urandom_range(0, 1);
                    h = $urandom_range(100, 600);
                end
                3:
                begin
                    w = $urandom_range(16, 64);
                    h = $urandom_range(1, FILL_PIXELS / w);
                end
                default:
                begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 12);
                end
            endcase
            case ($urandom_range(0, 9))
                0:          s = 0;
                1:          s = 64;
                2:          s = STRIDE_MAX;
                3:          s = $urandom_range(0, STRIDE_MAX);
                4, 5, 6:    s = $urandom_range(2, 4);
                default:    s = 1;
            endcase
            case ($urandom_range(0, 9))
                0:          t = 0;
                1:          t = LUMA_TOP;
                2:          t = THRESH_MAX;
                3:          t = $urandom_range(0, THRESH_MAX);
                4:          t = $urandom_range(0, 20000);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       t = W_BLUE;
                        1:       t = W_GREEN;
                        default: t = W_RED;
                    endcase
                    t = t * $urandom_range(1, 8);
                end
            endcase
            case ($urandom_range(0, 7))
                0, 1:       m = $urandom_range(0, 3);
                2:          m = CAP_MAX;
                3:          m = $urandom_range(0, CAP_MAX);
                default:    m = $urandom_range(4, 64);
            endcase
            // geometry always, the rest now and then
            mask = (sent == 0) ? ALL_REGS : {3'($urandom), 2'b11};
            configure(w, h, s, t, m, mask);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            n_pix     = $urandom_range(10, 90);
            for (int i = 0; i < n_pix; i++)
            begin
                if (i == 0)
                    sof = $urandom_range(0, 1);
                else if (peek_addr(1'b0) == '0)
                    sof = ($urandom_range(0, 4) != 0);
                else
                    sof = ($urandom_range(0, 39) == 0);
                // restart the raster before it walks past the filled addresses
                if (peek_addr(1'b0) >= FILL_PIXELS)
                    sof = 1'b1;
                send_random(sof);
            end
            sent += n_pix;
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // Single column with height clamped to 4096; walk down the filled addresses
    task automatic test_tall_frame();
        configure(1, DIM_MAX, 1, W_RED * 3, CAP_MAX, ALL_REGS);
        for (int i = 0; i < FILL_PIXELS; i++)
            send_random(i == 0);
    endtask

    // Hold the output off for a long stretch while pixels keep coming back to back
    task automatic test_backpressure();
        configure(8, 8, 1, 0, CAP_MAX, ALL_REGS);
        send_idle    = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 80; i++)
            send_random(i == 0);
        send_idle = 1'b1;
    endtask

    // Output side: after a taken event, stall at random while recv_idle is set, or for a requested hold-off
    initial
    begin : sink
        int unsigned n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            n = 0;
            if (hold_request > 0)
            begin
                n            = hold_request;
                hold_request = 0;
            end
            else if (out_valid && !out_stall && recv_idle)
                n = $urandom_range(0, 4);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each taken event against the oldest prediction
    always @(posedge clk)
    begin : event_check
        dvs_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected event: x=%0d y=%0d polarity=%0d", event_x, event_y,
                       polarity);
                mismatch_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_x !== want.x)
                begin
                    $error("event_x: expected %0d, got %0d", want.x, event_x);
                    mismatch_count++;
                end
                if (event_y !== want.y)
                begin
                    $error("event_y: expected %0d, got %0d", want.y, event_y);
                    mismatch_count++;
                end
                if (polarity !== want.pol)
                begin
                    $error("polarity: expected %0d, got %0d", want.pol, polarity);
                    mismatch_count++;
                end
                if (event_time !== want.stamp)
                begin
                    $error("event_time: expected %0h, got %0h", want.stamp, event_time);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        // hold every input at a known value through reset
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        blue           <= '0;
        green          <= '0;
        red            <= '0;
        start_of_frame <= 1'b0;
        frame_time     <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_FRAME_WIDTH;
        cfg_data       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reference_fill();
        test_directed();
        test_wide_rows();
        test_random_phases();
        test_tall_frame();
        test_backpressure();

        // drain, bounded, then give stray events a chance to show
        in_valid <= 1'b0;
        for (int n = 0; n < 5000 && expected_events.size() != 0; n++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $error("%0d predicted events never arrived", expected_events.size());
            mismatch_count += expected_events.size();
        end

        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
